/* hw/rtl/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	localparam logic [1:0] STATUS_INSERTED = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_SERVED   = 2'd2;
	localparam logic [1:0] STATUS_EMPTY    = 2'd3;

	typedef struct packed {
		logic        op;
		logic [15:0] client_id;
		logic [2:0]  prio_level;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] served_id;
		logic [2:0]  served_prio;
		logic [4:0]  occupancy;
	} out_word_t;

	typedef struct packed {
		logic [15:0] id;
		logic [2:0]  prio;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_WRITE_NEW,
		S_POP,
		S_RESULT
	} state_t;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_LAST,
		RD_PREV,
		RD_HEAD
	} rd_sel_t;

	typedef enum logic [1:0] {
		WR_NONE,
		WR_MOVE,
		WR_NEW
	} wr_sel_t;

	typedef struct packed {
		logic       latch;
		rd_sel_t    rd_sel;
		wr_sel_t    wr_sel;
		logic       load_pos;
		logic       pos_dec;
		logic       count_inc;
		logic       count_dec;
		logic       head_inc;
		logic       set_code;
		logic [1:0] code;
		logic       capture;
		logic       load_result;
	} cmd_t;

	typedef struct packed {
		logic is_remove;
		logic full;
		logic empty;
		logic lower;
		logic pos_one;
		logic out_busy;
	} stat_t;

endpackage

/* hw/rtl/spq_ctrl.sv */
`timescale 1ns / 1ps

module spq_ctrl
	import spq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_next = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (stat.is_remove) begin
					state_next = stat.empty ? S_RESULT : S_POP;
				end else if (stat.full) begin
					state_next = S_RESULT;
				end else if (stat.empty) begin
					state_next = S_WRITE_NEW;
				end else begin
					state_next = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!stat.lower) begin
					state_next = S_RESULT;
				end else if (stat.pos_one) begin
					state_next = S_WRITE_NEW;
				end
			end
			S_WRITE_NEW: state_next = S_RESULT;
			S_POP:       state_next = S_RESULT;
			S_RESULT: begin
				if (!stat.out_busy) begin
					state_next = S_IDLE;
				end
			end
			default: state_next = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.rd_sel = RD_NONE;
		cmd.wr_sel = WR_NONE;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				cmd.latch = in_valid;
			end
			S_DECIDE: begin
				if (stat.is_remove) begin
					if (stat.empty) begin
						cmd.set_code = 1'b1;
						cmd.code     = STATUS_EMPTY;
					end else begin
						cmd.rd_sel = RD_HEAD;
					end
				end else if (stat.full) begin
					cmd.set_code = 1'b1;
					cmd.code     = STATUS_FULL;
				end else begin
					// Scanning starts at the tail and moves toward the head.
					cmd.load_pos = 1'b1;
					if (!stat.empty) begin
						cmd.rd_sel = RD_LAST;
					end
				end
			end
			S_SCAN: begin
				if (stat.lower) begin
					cmd.wr_sel  = WR_MOVE;
					cmd.pos_dec = 1'b1;
					if (!stat.pos_one) begin
						cmd.rd_sel = RD_PREV;
					end
				end else begin
					cmd.wr_sel    = WR_NEW;
					cmd.count_inc = 1'b1;
					cmd.set_code  = 1'b1;
					cmd.code      = STATUS_INSERTED;
				end
			end
			S_WRITE_NEW: begin
				cmd.wr_sel    = WR_NEW;
				cmd.count_inc = 1'b1;
				cmd.set_code  = 1'b1;
				cmd.code      = STATUS_INSERTED;
			end
			S_POP: begin
				cmd.capture   = 1'b1;
				cmd.set_code  = 1'b1;
				cmd.code      = STATUS_SERVED;
				cmd.head_inc  = 1'b1;
				cmd.count_dec = 1'b1;
			end
			S_RESULT: begin
				cmd.load_result = !stat.out_busy;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* hw/rtl/spq_datapath.sv */
`timescale 1ns / 1ps

module spq_datapath
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  in_data,
	input  logic      out_stall,
	output logic      out_valid,
	output out_word_t out_data,
	input  cmd_t      cmd,
	output stat_t     stat
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = CW + 1;

	entry_t mem [QUEUE_DEPTH];

	logic           op_q;
	logic [15:0]    id_q;
	logic [2:0]     prio_q;
	logic [IW-1:0]  head_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  pos_q;
	entry_t         rd_q;
	logic [1:0]     code_q;
	logic [15:0]    served_id_q;
	logic [2:0]     served_prio_q;
	logic           out_valid_q;
	out_word_t      out_q;

	logic [CW-1:0]  rd_logical;
	logic [IW-1:0]  rd_addr;
	logic [IW-1:0]  wr_addr;
	entry_t         wr_data;

	// Queue order is kept relative to a moving head, so a remove never shifts.
	function automatic logic [IW-1:0] to_phys(input logic [IW-1:0] head,
			input logic [CW-1:0] logical);
		logic [SW-1:0] sum;
		sum = SW'(head) + SW'(logical);
		if (sum >= SW'(QUEUE_DEPTH)) begin
			sum = sum - SW'(QUEUE_DEPTH);
		end
		return sum[IW-1:0];
	endfunction

	always_comb begin
		case (cmd.rd_sel)
			RD_LAST: rd_logical = count_q - CW'(1);
			RD_PREV: rd_logical = pos_q - CW'(2);
			default: rd_logical = '0;
		endcase
		rd_addr = to_phys(head_q, rd_logical);
		wr_addr = to_phys(head_q, pos_q);
		if (cmd.wr_sel == WR_MOVE) begin
			wr_data = rd_q;
		end else begin
			wr_data.id   = id_q;
			wr_data.prio = prio_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_sel != WR_NONE) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_sel != RD_NONE) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= in_data.op;
			id_q   <= in_data.client_id;
			prio_q <= in_data.prio_level;
		end
		if (cmd.load_pos) begin
			pos_q <= count_q;
		end else if (cmd.pos_dec) begin
			pos_q <= pos_q - CW'(1);
		end
		if (cmd.set_code) begin
			code_q        <= cmd.code;
			served_id_q   <= cmd.capture ? rd_q.id : 16'd0;
			served_prio_q <= cmd.capture ? rd_q.prio : 3'd0;
		end
		if (cmd.load_result) begin
			out_q.status      <= code_q;
			out_q.served_id   <= served_id_q;
			out_q.served_prio <= served_prio_q;
			out_q.occupancy   <= 5'(count_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.head_inc) begin
				head_q <= (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + IW'(1);
			end
			if (cmd.count_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.load_result) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		stat.is_remove = (op_q == OP_REMOVE);
		stat.full      = (count_q == CW'(QUEUE_DEPTH));
		stat.empty     = (count_q == '0);
		stat.lower     = (rd_q.prio < prio_q);
		stat.pos_one   = (pos_q == CW'(1));
		stat.out_busy  = out_valid_q && out_stall;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* hw/rtl/stable_priority_queue_unit.sv */
`timescale 1ns / 1ps

// Priority waiting queue of up to QUEUE_DEPTH clients, served highest
// priority first and in arrival order among equal priorities. Each input word
// is an insert or a remove and yields exactly one result word. The block takes
// one word at a time. After the accepting edge the controller passes through
// S_DECIDE and then, for a refused insert or a remove from an empty queue,
// straight to S_RESULT, which loads the result register. A remove passes
// through S_POP and an insert into an empty queue through S_WRITE_NEW before
// S_RESULT. An insert into a non-empty queue walks in S_SCAN over the k stored
// entries of lower priority that move one place toward the tail, at most
// QUEUE_DEPTH - 1, one entry per cycle, as set by the single read and single
// write port of the entry memory. The next word can be accepted in the cycle
// after the result is loaded. A waiting result holds off the next word only if
// it has not been taken by the time the next result is due.
module stable_priority_queue_unit
	import spq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
)
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data
);

	cmd_t  cmd;
	stat_t stat;

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	spq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
